FILE: rtl/dcs_pkg.sv
// shared types and constants of the discrete cdf sampler
package dcs_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_LOAD   = 2'd1,
    FN_SAMPLE = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic CFG_MIN_ENERGY = 1'b0;
  localparam logic CFG_MAX_ENERGY = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CUM_W = 33;

  // one command held between the front and the back
  typedef struct packed {
    func_t       func;
    logic [31:0] energy_value;
    logic [23:0] entry_weight;
    logic [31:0] random_fraction;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [31:0] sampled_energy;
    logic [23:0] probability_weight;
    logic        accepted;
    status_t     status;
  } res_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_BS_RD,
    BK_BS_CMP,
    BK_FETCH,
    BK_SC_RD,
    BK_SC_CMP
  } bk_state_t;

endpackage

FILE: rtl/dcs_if.sv
// item channels of the discrete cdf sampler
interface dcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] energy_value;
  logic [23:0] entry_weight;
  logic [31:0] random_fraction;
  modport source (output valid, func, energy_value, entry_weight, random_fraction,
                  input ready);
  modport sink (input valid, func, energy_value, entry_weight, random_fraction,
                output ready);
endinterface

interface dcs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sampled_energy;
  logic [23:0] probability_weight;
  logic        accepted;
  logic [1:0]  status;
  modport source (output valid, sampled_energy, probability_weight, accepted, status,
                  input ready);
  modport sink (input valid, sampled_energy, probability_weight, accepted, status,
                output ready);
endinterface

FILE: rtl/dcs_front.sv
// front end: accepts items, decodes them and queues commands for the back end
module dcs_front import dcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  dcs_in_if.sink in_ch,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_pop
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          push;
  cmd_t          in_cmd;

  // decode the incoming item
  always_comb begin
    in_cmd.func            = func_t'(in_ch.func);
    in_cmd.energy_value    = in_ch.energy_value;
    in_cmd.entry_weight    = in_ch.entry_weight;
    in_cmd.random_fraction = in_ch.random_fraction;
  end

  assign in_ch.ready = (cnt_r != NW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (cmd_pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

endmodule

FILE: rtl/dcs_back.sv
// back end: table storage, binary search sampling, linear query scan
module dcs_back import dcs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [31:0] min_energy,
  input  logic [31:0] max_energy,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = 32 + CUM_W;

  // table memory: energy in the upper bits, cumulative weight below
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_ra;
  logic [MW-1:0] mem_wd;

  bk_state_t        st_r, st_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CUM_W-1:0] tw_r, tw_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [CUM_W-1:0] target_r, target_nxt;
  logic [CW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CUM_W-1:0] prev_r, prev_nxt;
  logic             res_valid_r, res_valid_nxt;
  res_t             res_r, res_nxt;

  logic             start;
  logic [CW:0]      lo_hi_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    lo_clamp;
  logic [CUM_W:0]   load_sum;
  logic [CUM_W-1:0] rd_cum, cum_diff;
  logic [31:0]      rd_energy;

  assign start     = (st_r == BK_IDLE) && cmd_valid && (!res_valid_r || res_take);
  assign cmd_pop   = start;
  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = lo_hi_sum[CW:1];
  assign lo_clamp  = (lo_r >= count_r) ? count_r - 1'b1 : lo_r;
  assign load_sum  = {1'b0, tw_r} + (CUM_W + 1)'(cmd.entry_weight);
  assign rd_cum    = rd_q[CUM_W-1:0];
  assign rd_energy = rd_q[MW-1:CUM_W];
  assign cum_diff  = rd_cum - prev_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (start) begin
          if (cmd.func == FN_SAMPLE && count_r != '0 && tw_r != '0) begin
            st_nxt = BK_MUL;
          end else if (cmd.func == FN_QUERY && count_r != '0) begin
            st_nxt = BK_SC_RD;
          end
        end
      end
      BK_MUL:    st_nxt = BK_ADD;
      BK_ADD:    st_nxt = BK_BS_RD;
      BK_BS_RD:  st_nxt = (lo_r < hi_r) ? BK_BS_CMP : BK_FETCH;
      BK_BS_CMP: st_nxt = BK_BS_RD;
      BK_FETCH:  st_nxt = BK_IDLE;
      BK_SC_RD:  st_nxt = BK_SC_CMP;
      BK_SC_CMP: begin
        if (rd_energy == cmd_r.energy_value || idx_r + 1'b1 == count_r) begin
          st_nxt = BK_IDLE;
        end else begin
          st_nxt = BK_SC_RD;
        end
      end
      default:   st_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    tw_nxt        = tw_r;
    prod_nxt      = prod_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_take;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    mem_wd        = {cmd.energy_value, load_sum[CUM_W-1:0]};
    unique case (st_r)
      BK_IDLE: begin
        if (start) begin
          cmd_nxt = cmd;
          res_nxt = '{sampled_energy: '0, probability_weight: '0, accepted: 1'b0,
                      status: ST_OK};
          idx_nxt  = '0;
          prev_nxt = '0;
          unique case (cmd.func)
            FN_CLEAR: begin
              count_nxt     = '0;
              tw_nxt        = '0;
              res_valid_nxt = 1'b1;
            end
            FN_LOAD: begin
              res_valid_nxt = 1'b1;
              if (count_r >= CW'(TABLE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                // saturating running sum
                if (load_sum[CUM_W]) begin
                  mem_wd = {cmd.energy_value, {CUM_W{1'b1}}};
                end
                tw_nxt    = mem_wd[CUM_W-1:0];
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            FN_SAMPLE: begin
              if (count_r == '0 || tw_r == '0) begin
                res_nxt.status = ST_EMPTY;
                res_valid_nxt  = 1'b1;
              end
            end
            FN_QUERY: begin
              if (count_r == '0) begin
                res_valid_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_MUL: begin
        prod_nxt = 64'(tw_r[31:0]) * 64'(cmd_r.random_fraction);
      end
      BK_ADD: begin
        target_nxt = CUM_W'(prod_r[63:32]) +
                     (tw_r[32] ? CUM_W'(cmd_r.random_fraction) : '0);
        lo_nxt = '0;
        hi_nxt = count_r;
      end
      BK_BS_RD: begin
        mem_re = 1'b1;
        if (lo_r < hi_r) begin
          mem_ra  = mid[AW-1:0];
          mid_nxt = mid;
        end else begin
          mem_ra = lo_clamp[AW-1:0];
        end
      end
      BK_BS_CMP: begin
        if (rd_cum > target_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + 1'b1;
        end
      end
      BK_FETCH: begin
        res_nxt.sampled_energy = rd_energy;
        res_nxt.accepted       = (rd_energy > min_energy) && (rd_energy < max_energy);
        res_valid_nxt          = 1'b1;
      end
      BK_SC_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_r[AW-1:0];
      end
      BK_SC_CMP: begin
        if (rd_energy == cmd_r.energy_value) begin
          res_nxt.probability_weight = cum_diff[23:0];
          res_valid_nxt              = 1'b1;
        end else if (idx_r + 1'b1 == count_r) begin
          res_valid_nxt = 1'b1;
        end else begin
          prev_nxt = rd_cum;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      count_r     <= '0;
      tw_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      tw_r        <= tw_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    prod_r   <= prod_nxt;
    target_r <= target_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    idx_r    <= idx_nxt;
    prev_r   <= prev_nxt;
    res_r    <= res_nxt;
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

endmodule

FILE: rtl/discrete_cdf_sampler_unit.sv
// top level of the discrete cdf sampler
//
//  port      | dir | contents
//  in_ch     | in  | func, energy_value, entry_weight, random_fraction
//  out_ch    | out | sampled_energy, probability_weight, accepted, status
//  cfg_*     | in  | write enable, register index, 32-bit data
//
// clear and load finish in the back end's idle state; a sample runs a multiply, an add,
// a binary search over the n entries paced by the single table read port, and a fetch.
// a query scans the table one entry at a time and stops at a match or at the last entry.
// rst_n is synchronous: empties the table and the queue, sets the window to full range.
// a 2-entry command queue takes items while a result waits on out_ch.
module discrete_cdf_sampler_unit import dcs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  dcs_in_if.sink      in_ch,
  dcs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic        cmd_valid, cmd_pop, res_valid;
  cmd_t        cmd;
  res_t        res;
  logic [31:0] min_energy_r, max_energy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_energy_r <= '0;
      max_energy_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_ENERGY: min_energy_r <= cfg_wdata;
        CFG_MAX_ENERGY: max_energy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dcs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .min_energy (min_energy_r),
    .max_energy (max_energy_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (out_ch.valid && out_ch.ready)
  );

  // result channel
  assign out_ch.valid              = res_valid;
  assign out_ch.sampled_energy     = res.sampled_energy;
  assign out_ch.probability_weight = res.probability_weight;
  assign out_ch.accepted           = res.accepted;
  assign out_ch.status             = res.status;

endmodule
